/* sv/mcc_pkg.sv */
package mcc_pkg;

    localparam int CmdWidth   = 3;
    localparam int IndexWidth = 10;

    localparam logic [CmdWidth-1:0] CMD_LOAD   = 3'd0;
    localparam logic [CmdWidth-1:0] CMD_STORE  = 3'd1;
    localparam logic [CmdWidth-1:0] CMD_RESP   = 3'd2;
    localparam logic [CmdWidth-1:0] CMD_SNOOP  = 3'd3;
    localparam logic [CmdWidth-1:0] CMD_EVICT  = 3'd4;

    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_E = 2'd1;
    localparam logic [1:0] ST_S = 2'd2;
    localparam logic [1:0] ST_M = 2'd3;

    localparam logic BUS_RD  = 1'b0;
    localparam logic BUS_RDX = 1'b1;

    localparam logic [1:0] CLS_NONE    = 2'd0;
    localparam logic [1:0] CLS_PRIVATE = 2'd1;
    localparam logic [1:0] CLS_SHARED  = 2'd2;

    typedef struct packed {
        logic [CmdWidth-1:0]   command;
        logic [IndexWidth-1:0] block_index;
        logic                  bus_kind;
        logic                  shared_asserted;
    } t_in_item;

    typedef struct packed {
        logic       access_done;
        logic       request_valid;
        logic       request_kind;
        logic       flush_needed;
        logic [1:0] access_class;
        logic       miss;
        logic [1:0] result_state;
        logic       protocol_error;
    } t_out_item;

endpackage

/* sv/mesi_coherence_controller.sv */
// MESI state store for NUM_BLOCKS cache blocks, one two-bit state per block held in a
// single-port-write synchronous memory. After reset the block sweeps the memory to Invalid,
// one entry a cycle; o_in_stall stays high during that sweep. Then it takes one event per
// cycle while the output is not stalled: the state is read at the input transfer edge, the
// next state is computed from the registered event and written back at the edge where that
// event leaves this stage, where the result also lands in the output register. A stalled
// result holds the event behind it, and that one holds the input. Back-to-back events on the
// same block are handled by forwarding the state just written. Block numbers at or beyond
// NUM_BLOCKS read as Invalid and are never written.
module mesi_coherence_controller
    import mcc_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int IW = (AW > IndexWidth) ? AW : IndexWidth;
    localparam logic [AW-1:0] LastAddr = AW'(NUM_BLOCKS - 1);

    logic [1:0] mem [NUM_BLOCKS];

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic          r_s1_valid;
    t_in_item      r_s1_item;
    logic [1:0]    r_rd_data;

    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [1:0]    r_fwd_state;

    logic          r_out_valid;
    t_out_item     r_out_item;

    logic          in_fire;
    logic          s1_fire;
    logic [IW-1:0] in_ext;
    logic [AW-1:0] in_addr;
    logic [IW-1:0] s1_ext;
    logic [AW-1:0] s1_addr;
    logic          s1_in_range;
    logic [1:0]    cur_state;
    t_out_item     s1_result;
    logic          s1_state_write;
    logic          s1_we;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [1:0]    mem_wdata;

    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clearing || (r_s1_valid && !s1_fire);
    assign in_fire    = i_in_valid && !o_in_stall;

    assign in_ext  = IW'(i_in_item.block_index);
    assign in_addr = in_ext[AW-1:0];
    assign s1_ext  = IW'(r_s1_item.block_index);
    assign s1_addr = s1_ext[AW-1:0];
    assign s1_in_range = 32'(r_s1_item.block_index) < 32'(NUM_BLOCKS);

    // the previous event wrote this entry on the same edge as this read
    always_comb begin
        priority if (!s1_in_range) begin
            cur_state = ST_I;
        end else if (r_fwd_valid && (r_fwd_addr == s1_addr)) begin
            cur_state = r_fwd_state;
        end else begin
            cur_state = r_rd_data;
        end
    end

    mcc_transition u_transition (
        .i_command         (r_s1_item.command),
        .i_bus_kind        (r_s1_item.bus_kind),
        .i_shared_asserted (r_s1_item.shared_asserted),
        .i_cur_state       (cur_state),
        .o_result          (s1_result),
        .o_state_write     (s1_state_write)
    );

    assign s1_we = s1_fire && s1_state_write && s1_in_range;

    always_comb begin
        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = ST_I;
        end else begin
            mem_we    = s1_we;
            mem_waddr = s1_addr;
            mem_wdata = s1_result.result_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire) begin
            r_rd_data <= mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LastAddr) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_fire) begin
                r_s1_valid  <= 1'b1;
                r_fwd_valid <= s1_we;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item   <= i_in_item;
            r_fwd_addr  <= s1_addr;
            r_fwd_state <= s1_result.result_state;
        end
        if (s1_fire) begin
            r_out_item <= s1_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* sv/mcc_transition.sv */
module mcc_transition
    import mcc_pkg::*;
(
    input  logic [CmdWidth-1:0] i_command,
    input  logic                i_bus_kind,
    input  logic                i_shared_asserted,
    input  logic [1:0]          i_cur_state,
    output t_out_item           o_result,
    output logic                o_state_write
);

    logic [1:0] nxt;
    logic       err;

    always_comb begin
        o_result = '0;
        nxt      = i_cur_state;
        err      = 1'b0;
        unique case (i_command)
            CMD_LOAD, CMD_STORE: begin
                if (i_cur_state == ST_I) begin
                    o_result.request_valid = 1'b1;
                    o_result.request_kind  = (i_command == CMD_STORE) ? BUS_RDX : BUS_RD;
                    o_result.miss          = 1'b1;
                end else if (i_cur_state == ST_S) begin
                    if (i_command == CMD_STORE) begin
                        o_result.request_valid = 1'b1;
                        o_result.request_kind  = BUS_RDX;
                    end else begin
                        o_result.access_done  = 1'b1;
                        o_result.access_class = CLS_SHARED;
                    end
                end else begin
                    o_result.access_done  = 1'b1;
                    o_result.access_class = CLS_PRIVATE;
                    if (i_command == CMD_STORE) begin
                        nxt = ST_M;
                    end
                end
            end
            CMD_RESP: begin
                if (i_bus_kind == BUS_RD) begin
                    if (i_cur_state == ST_I) begin
                        nxt = i_shared_asserted ? ST_S : ST_E;
                        o_result.access_class = i_shared_asserted ? CLS_SHARED : CLS_PRIVATE;
                    end else begin
                        err = 1'b1;
                    end
                end else begin
                    if (i_cur_state != ST_M) begin
                        nxt = ST_M;
                        o_result.access_class = CLS_PRIVATE;
                    end else begin
                        err = 1'b1;
                    end
                end
            end
            CMD_SNOOP: begin
                if (i_cur_state != ST_I) begin
                    o_result.flush_needed = (i_cur_state == ST_M);
                    nxt = (i_bus_kind == BUS_RDX) ? ST_I : ST_S;
                end
            end
            CMD_EVICT: begin
                nxt = ST_I;
            end
            default: begin
                err = 1'b1;
            end
        endcase
        // an illegal event leaves the state as it was
        if (err) begin
            nxt = i_cur_state;
        end
        o_result.result_state   = nxt;
        o_result.protocol_error = err;
        o_state_write           = !err;
    end

endmodule

/* bench/tb_mesi_coherence_controller.sv */
`timescale 1ns / 100ps

module tb_mesi_coherence_controller;
    import mcc_pkg::*;

    localparam int NumBlocks    = 1024;
    localparam int RandomEvents = 1125;
    localparam int SegmentLen   = 150;
    localparam int IdleLimit    = 4 * (NumBlocks + 64);
    localparam int DrainCycles  = 8;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_item;

    mesi_coherence_controller #(
        .NUM_BLOCKS (NumBlocks)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    logic [1:0] line_state [NumBlocks];
    t_out_item  expected_results [$];
    t_out_item  last_prediction;
    int         failures;
    int         events_sent;
    int         idle_cycles = 0;
    bit         steady;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // next state and side outputs of one event, applied to the local copy of the store
    function automatic t_out_item apply_mesi_event(input t_in_item ev);
        t_out_item  r;
        logic [1:0] cur;
        logic [1:0] nxt;
        logic       is_store;
        r   = '0;
        cur = (int'(ev.block_index) < NumBlocks) ? line_state[ev.block_index] : ST_I;
        nxt = cur;
        case (ev.command)
            CMD_LOAD, CMD_STORE: begin
                is_store = (ev.command == CMD_STORE);
                if (cur == ST_I) begin
                    r.request_valid = 1'b1;
                    r.request_kind  = is_store ? BUS_RDX : BUS_RD;
                    r.miss          = 1'b1;
                end else if (cur == ST_S) begin
                    if (is_store) begin
                        r.request_valid = 1'b1;
                        r.request_kind  = BUS_RDX;
                    end else begin
                        r.access_done  = 1'b1;
                        r.access_class = CLS_SHARED;
                    end
                end else begin
                    r.access_done  = 1'b1;
                    r.access_class = CLS_PRIVATE;
                    if (is_store) nxt = ST_M;
                end
            end
            CMD_RESP: begin
                if (ev.bus_kind == BUS_RD) begin
                    if (cur == ST_I) begin
                        nxt            = ev.shared_asserted ? ST_S : ST_E;
                        r.access_class = ev.shared_asserted ? CLS_SHARED : CLS_PRIVATE;
                    end else begin
                        r.protocol_error = 1'b1;
                    end
                end else if (cur != ST_M) begin
                    nxt            = ST_M;
                    r.access_class = CLS_PRIVATE;
                end else begin
                    r.protocol_error = 1'b1;
                end
            end
            CMD_SNOOP: begin
                if (cur != ST_I) begin
                    r.flush_needed = (cur == ST_M);
                    nxt            = (ev.bus_kind == BUS_RDX) ? ST_I : ST_S;
                end
            end
            CMD_EVICT: nxt = ST_I;
            default:   r.protocol_error = 1'b1;
        endcase
        if (!r.protocol_error && int'(ev.block_index) < NumBlocks)
            line_state[ev.block_index] = nxt;
        r.result_state = nxt;
        return r;
    endfunction

    task automatic send_event(input logic [CmdWidth-1:0] cmd, input logic [IndexWidth-1:0] idx,
                              input logic kind, input logic shr);
        int       gap;
        t_in_item ev;
        ev  = '{command: cmd, block_index: idx, bus_kind: kind, shared_asserted: shr};
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= ev;
        do @(posedge i_clk); while (o_in_stall);
        last_prediction = apply_mesi_event(ev);
        expected_results.push_back(last_prediction);
        events_sent++;
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [1:0] want, input logic [1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $error("result transfer with nothing outstanding: %p", got);
            failures++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("access_done", want.access_done, got.access_done);
        compare_field("request_valid", want.request_valid, got.request_valid);
        compare_field("request_kind", want.request_kind, got.request_kind);
        compare_field("flush_needed", want.flush_needed, got.flush_needed);
        compare_field("access_class", want.access_class, got.access_class);
        compare_field("miss", want.miss, got.miss);
        compare_field("result_state", want.result_state, got.result_state);
        compare_field("protocol_error", want.protocol_error, got.protocol_error);
    endtask

    // result side: random hold-off per transfer, then take it and check it
    initial begin
        int hold;
        i_out_stall <= 1'b0;
        forever begin
            hold = steady ? 0 : $urandom_range(0, 13);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
            check_result(o_out_item);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_load_fill();
        send_event(CMD_LOAD, 10'd0, BUS_RD, 1'b0);
        send_event(CMD_RESP, 10'd0, BUS_RD, 1'b0);
        send_event(CMD_LOAD, 10'd0, BUS_RD, 1'b0);
        send_event(CMD_LOAD, 10'd1023, BUS_RD, 1'b1);
        send_event(CMD_RESP, 10'd1023, BUS_RD, 1'b1);
        send_event(CMD_LOAD, 10'd1023, BUS_RD, 1'b0);
    endtask

    task automatic test_store_upgrade();
        send_event(CMD_STORE, 10'd0, BUS_RD, 1'b0);
        send_event(CMD_STORE, 10'd0, BUS_RDX, 1'b1);
        send_event(CMD_STORE, 10'd1023, BUS_RD, 1'b0);
        send_event(CMD_RESP, 10'd1023, BUS_RDX, 1'b0);
        send_event(CMD_STORE, 10'd682, BUS_RD, 1'b0);
        send_event(CMD_RESP, 10'd682, BUS_RDX, 1'b1);
    endtask

    task automatic test_snoop_paths();
        send_event(CMD_SNOOP, 10'd0, BUS_RD, 1'b0);
        send_event(CMD_SNOOP, 10'd0, BUS_RDX, 1'b0);
        send_event(CMD_SNOOP, 10'd0, BUS_RD, 1'b1);
        send_event(CMD_SNOOP, 10'd1023, BUS_RDX, 1'b0);
        send_event(CMD_LOAD, 10'd341, BUS_RD, 1'b0);
        send_event(CMD_RESP, 10'd341, BUS_RD, 1'b0);
        send_event(CMD_SNOOP, 10'd341, BUS_RD, 1'b0);
    endtask

    task automatic test_illegal_events();
        send_event(CMD_RESP, 10'd341, BUS_RD, 1'b1);
        send_event(CMD_RESP, 10'd341, BUS_RDX, 1'b0);
        send_event(CMD_RESP, 10'd341, BUS_RDX, 1'b0);
        send_event(CMD_EVICT, 10'd341, BUS_RDX, 1'b1);
        // codes past evict are undefined and must leave a modified block alone
        for (int c = int'(CMD_EVICT) + 1; c < (1 << CmdWidth); c++)
            send_event(c[CmdWidth-1:0], 10'd682, BUS_RDX, 1'b1);
    endtask

    task automatic test_random_traffic();
        logic [IndexWidth-1:0] hot_blocks [16];
        logic [IndexWidth-1:0] idx;
        logic                  is_store;
        int                    first;
        int                    pick;
        int                    next_segment;
        bit                    paused;
        first        = events_sent;
        next_segment = events_sent;
        paused       = 1'b0;
        foreach (hot_blocks[i]) hot_blocks[i] = IndexWidth'($urandom_range(0, NumBlocks - 1));
        while (events_sent - first < RandomEvents) begin
            if (events_sent >= next_segment) begin
                steady       = ($urandom_range(0, 3) == 0);
                next_segment = events_sent + SegmentLen;
            end
            if (!paused && events_sent - first >= RandomEvents / 2) begin
                wait_for_drain();
                paused = 1'b1;
            end
            idx  = ($urandom_range(0, 4) != 0) ? hot_blocks[$urandom_range(0, 15)]
                                               : IndexWidth'($urandom_range(0, NumBlocks - 1));
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // core access, answered by the matching bus response when one is issued
                is_store = 1'($urandom_range(0, 1));
                send_event(is_store ? CMD_STORE : CMD_LOAD, idx, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                if (last_prediction.request_valid) begin
                    if ($urandom_range(0, 3) == 0)
                        send_event(CMD_SNOOP, idx, 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1)));
                    send_event(CMD_RESP, idx, last_prediction.request_kind,
                               1'($urandom_range(0, 1)));
                end
            end else if (pick < 70) begin
                send_event(CMD_SNOOP, idx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 80) begin
                send_event(CMD_EVICT, idx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                send_event(CmdWidth'($urandom_range(0, (1 << CmdWidth) - 1)), idx,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        failures    = 0;
        events_sent = 0;
        steady      = 1'b0;
        foreach (line_state[i]) line_state[i] = ST_I;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_load_fill();
        test_store_upgrade();
        test_snoop_paths();
        test_illegal_events();
        wait_for_drain();
        test_random_traffic();

        wait_for_drain();
        repeat (DrainCycles) @(posedge i_clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
